### src/erest_pkg.sv
`default_nettype none
package erest_pkg;

    localparam int MAX_SAMPLES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int VAL_W      = 48;
    localparam int Q_W        = 49;
    localparam int ELAP_W     = 40;
    localparam int CNT_W      = 32;
    localparam int MODE_W     = 2;
    localparam int SCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_DIST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACC  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RST = MODE_VEL;
    localparam logic [SCNT_W-1:0] SCNT_RST = 5'd2;

    typedef enum logic [1:0] {
        SRC_VEL,
        SRC_ACC,
        SRC_MEAN
    } div_src_t;

    typedef enum logic {
        HIST_VEL,
        HIST_ACC
    } hist_sel_t;

    typedef struct packed {
        logic      accum;
        logic      dist_res;
        logic      zero_res;
        logic      vprev_rd;
        logic      v_zero;
        logic      div_start;
        div_src_t  div_src;
        logic      v_take;
        logic      a_zero;
        logic      a_take;
        logic      a_push;
        logic      v_push;
        hist_sel_t hist_sel;
        logic      sum_clear;
        logic      sum_rd;
        logic      mean_take;
        logic      clear_acc;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic elap_zero;
        logic div_done;
        logic sum_last;
    } status_t;

endpackage
`default_nettype wire

### src/erest_div.sv
`default_nettype none
module erest_div #(
    parameter int NUM_W = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              start,
    input  wire  [NUM_W-1:0]                 num,
    input  wire  [erest_pkg::ELAP_W-1:0]     den,
    output logic                             done,
    output logic [erest_pkg::Q_W-1:0]        quot,
    output logic                             ovf
);

    localparam int DW = erest_pkg::ELAP_W;
    localparam int QW = erest_pkg::Q_W;
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      rem_reg;
    logic [QW-1:0]    quot_reg;
    logic             ovf_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0] rem_sh;
    logic        ge;
    logic [DW:0] rem_next;

    assign rem_sh   = {rem_reg[DW-1:0], num_reg[NUM_W-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign rem_next = ge ? rem_sh - {1'b0, den_reg} : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QW-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[QW-1];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

### src/erest_hist.sv
`default_nettype none
module erest_hist #(
    parameter int DEPTH = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   push,
    input  wire  [erest_pkg::VAL_W-1:0]           push_data,
    input  wire  [$clog2(DEPTH+1)-1:0]            cap,
    input  wire                                   rd_en,
    input  wire  [$clog2(DEPTH)-1:0]              rd_age,
    output logic [erest_pkg::VAL_W-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0]            fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [erest_pkg::VAL_W-1:0] mem [DEPTH];
    logic [erest_pkg::VAL_W-1:0] rd_data_reg;
    logic [AW-1:0]               wp_reg;
    logic [AW-1:0]               wp_next;
    logic [FW-1:0]               fill_reg;
    logic [FW:0]                 fill_inc;
    logic [AW-1:0]               rd_addr;
    logic [AW:0]                 wrap_addr;

    assign wp_next   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign wrap_addr = {1'b0, wp_reg} + (AW+1)'(DEPTH) - {1'b0, rd_age};
    assign rd_addr   = (rd_age > wp_reg) ? wrap_addr[AW-1:0] : wp_reg - rd_age;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end else if (push) begin
            wp_reg   <= wp_next;
            fill_reg <= (fill_inc < {1'b0, cap}) ? fill_inc[FW-1:0] : cap;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_next] <= push_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule
`default_nettype wire

### src/erest_dp.sv
`default_nettype none
module erest_dp #(
    parameter int MAX_SAMPLES = erest_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = erest_pkg::FRAC_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  erest_pkg::cmd_t                      cmd,
    input  wire  [$clog2(MAX_SAMPLES+1)-1:0]     n_eff,
    input  wire  signed [erest_pkg::CNT_W-1:0]   delta_counts,
    input  wire  [erest_pkg::CNT_W-1:0]          delta_ticks,
    output erest_pkg::status_t                   status,
    output logic signed [erest_pkg::VAL_W-1:0]   out_value,
    output logic                                 out_clip
);

    localparam int VW    = erest_pkg::VAL_W;
    localparam int QW    = erest_pkg::Q_W;
    localparam int EW    = erest_pkg::ELAP_W;
    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int FW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = VW + $clog2(MAX_SAMPLES + 1);
    localparam int SH_W  = VW + FRAC_BITS;
    localparam int NUM_W = (SH_W > SUM_W) ? SH_W : SUM_W;

    localparam logic [QW-1:0] POS47 = QW'(1) << (VW - 1);

    logic signed [VW-1:0]    dist_reg;
    logic [EW-1:0]           elap_reg;
    logic                    clip_reg;
    logic signed [VW-1:0]    v_reg;
    logic signed [VW-1:0]    a_reg;
    logic signed [VW-1:0]    res_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [FW-1:0]           age_reg;
    logic                    pend_reg;
    logic                    neg_reg;
    logic signed [VW-1:0]    m_value_reg;
    logic                    m_clip_reg;

    logic signed [VW:0]   d_sum;
    logic [EW:0]          e_sum;
    logic [VW-1:0]        dist_mag;
    logic [SH_W-1:0]      dist_sh;
    logic [VW:0]          sat_dist;
    logic [VW:0]          sat_div;
    logic signed [VW-1:0] vprev;
    logic signed [VW:0]   dv;
    logic [VW:0]          dv_mag;
    logic [SUM_W-1:0]     sum_mag;
    logic [NUM_W-1:0]     div_num;
    logic [EW-1:0]        div_den;
    logic                 div_neg;
    logic                 div_done;
    logic [QW-1:0]        div_quot;
    logic                 div_ovf;

    logic [VW-1:0] vel_rd;
    logic [VW-1:0] acc_rd;
    logic [FW-1:0] vel_fill;
    logic [FW-1:0] acc_fill;
    logic [FW-1:0] fill_sel;
    logic [VW-1:0] rd_sel;
    logic          vel_rd_en;
    logic          acc_rd_en;

    function automatic logic [VW:0] sat48(input logic neg, input logic [QW-1:0] mag,
                                          input logic ovf);
        logic [QW-1:0] lim;
        logic [QW-1:0] m;
        logic          c;
        lim = neg ? POS47 : POS47 - 1'b1;
        c   = ovf || (mag > lim);
        m   = c ? lim : mag;
        m   = neg ? QW'(0) - m : m;
        return {c, m[VW-1:0]};
    endfunction

    assign d_sum    = (VW+1)'(dist_reg) + (VW+1)'(delta_counts);
    assign e_sum    = {1'b0, elap_reg} + (EW+1)'(delta_ticks);
    assign dist_mag = dist_reg[VW-1] ? VW'(0) - dist_reg : dist_reg;
    assign dist_sh  = {dist_mag, {FRAC_BITS{1'b0}}};
    assign sat_dist = sat48(dist_reg[VW-1], dist_sh[QW-1:0], |dist_sh[SH_W-1:QW]);
    assign sat_div  = sat48(neg_reg, div_quot, div_ovf);

    assign vprev   = (vel_fill != '0) ? vel_rd : '0;
    assign dv      = (VW+1)'(v_reg) - (VW+1)'(vprev);
    assign dv_mag  = dv[VW] ? (VW+1)'(0) - dv : dv;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(0) - sum_reg : sum_reg;

    always_comb begin
        div_num = NUM_W'(dist_sh);
        div_den = elap_reg;
        div_neg = dist_reg[VW-1];
        case (cmd.div_src)
            erest_pkg::SRC_VEL: begin
                div_num = NUM_W'(dist_sh);
                div_den = elap_reg;
                div_neg = dist_reg[VW-1];
            end
            erest_pkg::SRC_ACC: begin
                div_num = NUM_W'(dv_mag);
                div_den = elap_reg;
                div_neg = dv[VW];
            end
            erest_pkg::SRC_MEAN: begin
                div_num = NUM_W'(sum_mag);
                div_den = EW'(fill_sel);
                div_neg = sum_reg[SUM_W-1];
            end
            default: begin
                div_num = NUM_W'(dist_sh);
                div_den = elap_reg;
                div_neg = dist_reg[VW-1];
            end
        endcase
    end

    erest_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    assign vel_rd_en = cmd.vprev_rd || (cmd.sum_rd && cmd.hist_sel == erest_pkg::HIST_VEL);
    assign acc_rd_en = cmd.sum_rd && cmd.hist_sel == erest_pkg::HIST_ACC;

    erest_hist #(
        .DEPTH (MAX_SAMPLES)
    ) u_vel_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd.v_push),
        .push_data (v_reg),
        .cap       (n_eff),
        .rd_en     (vel_rd_en),
        .rd_age    (cmd.vprev_rd ? AW'(0) : age_reg[AW-1:0]),
        .rd_data   (vel_rd),
        .fill      (vel_fill)
    );

    erest_hist #(
        .DEPTH (MAX_SAMPLES)
    ) u_acc_hist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd.a_push),
        .push_data (a_reg),
        .cap       (n_eff),
        .rd_en     (acc_rd_en),
        .rd_age    (age_reg[AW-1:0]),
        .rd_data   (acc_rd),
        .fill      (acc_fill)
    );

    assign fill_sel = (cmd.hist_sel == erest_pkg::HIST_ACC) ? acc_fill : vel_fill;
    assign rd_sel   = (cmd.hist_sel == erest_pkg::HIST_ACC) ? acc_rd : vel_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= '0;
            elap_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.sum_rd;
            if (cmd.accum) begin
                if (d_sum[VW] != d_sum[VW-1]) begin
                    dist_reg <= d_sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
                end else begin
                    dist_reg <= d_sum[VW-1:0];
                end
                elap_reg <= e_sum[EW] ? {EW{1'b1}} : e_sum[EW-1:0];
            end else if (cmd.clear_acc) begin
                dist_reg <= '0;
                elap_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accum) begin
            clip_reg <= (d_sum[VW] != d_sum[VW-1]) || e_sum[EW];
        end else if (cmd.dist_res) begin
            clip_reg <= clip_reg | sat_dist[VW];
        end else if (cmd.v_take || cmd.a_take || cmd.mean_take) begin
            clip_reg <= clip_reg | sat_div[VW];
        end
        if (cmd.div_start) begin
            neg_reg <= div_neg;
        end
        if (cmd.v_zero) begin
            v_reg <= '0;
        end else if (cmd.v_take) begin
            v_reg <= sat_div[VW-1:0];
        end
        if (cmd.a_zero) begin
            a_reg <= '0;
        end else if (cmd.a_take) begin
            a_reg <= sat_div[VW-1:0];
        end
        if (cmd.dist_res) begin
            res_reg <= sat_dist[VW-1:0];
        end else if (cmd.zero_res) begin
            res_reg <= '0;
        end else if (cmd.mean_take) begin
            res_reg <= sat_div[VW-1:0];
        end
        if (cmd.sum_clear) begin
            sum_reg <= '0;
            age_reg <= '0;
        end else begin
            if (cmd.sum_rd) begin
                age_reg <= age_reg + 1'b1;
            end
            if (pend_reg) begin
                sum_reg <= sum_reg + SUM_W'(signed'(rd_sel));
            end
        end
        if (cmd.out_load) begin
            m_value_reg <= res_reg;
            m_clip_reg  <= clip_reg;
        end
    end

    assign status.elap_zero = (elap_reg == '0);
    assign status.div_done  = div_done;
    assign status.sum_last  = (age_reg == fill_sel - 1'b1);

    assign out_value = m_value_reg;
    assign out_clip  = m_clip_reg;

endmodule
`default_nettype wire

### src/erest_ctrl.sv
`default_nettype none
module erest_ctrl #(
    parameter int MAX_SAMPLES = erest_pkg::MAX_SAMPLES_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [erest_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [erest_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  erest_pkg::status_t                   status,
    output erest_pkg::cmd_t                      cmd,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]     n_eff
);

    localparam int FW = $clog2(MAX_SAMPLES + 1);
    localparam int CW = (FW > erest_pkg::SCNT_W) ? FW : erest_pkg::SCNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_VDIV,
        S_ASTART,
        S_ADIV,
        S_APUSH,
        S_VPUSH,
        S_SUMCLR,
        S_SUMRD,
        S_SUMTAIL,
        S_MSTART,
        S_MDIV,
        S_OUT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic                            m_valid_reg;
    logic [erest_pkg::MODE_W-1:0]    mode_reg;
    logic [erest_pkg::SCNT_W-1:0]    count_reg;
    logic [CW-1:0]                   count_ext;
    logic                            is_acc;

    assign count_ext = CW'(count_reg);
    assign n_eff     = (count_reg == '0) ? FW'(1) :
                       (count_ext > CW'(MAX_SAMPLES)) ? FW'(MAX_SAMPLES) : FW'(count_ext);
    assign is_acc    = (mode_reg == erest_pkg::MODE_ACC);

    always_comb begin
        cmd          = '0;
        cmd.hist_sel = is_acc ? erest_pkg::HIST_ACC : erest_pkg::HIST_VEL;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accum  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cmd.vprev_rd = 1'b1;
                case (mode_reg)
                    erest_pkg::MODE_DIST: begin
                        cmd.dist_res = 1'b1;
                        state_next   = S_OUT;
                    end
                    erest_pkg::MODE_VEL, erest_pkg::MODE_ACC: begin
                        if (status.elap_zero) begin
                            cmd.v_zero = 1'b1;
                            state_next = is_acc ? S_ASTART : S_VPUSH;
                        end else begin
                            cmd.div_start = 1'b1;
                            cmd.div_src   = erest_pkg::SRC_VEL;
                            state_next    = S_VDIV;
                        end
                    end
                    default: begin
                        cmd.zero_res = 1'b1;
                        state_next   = S_OUT;
                    end
                endcase
            end
            S_VDIV: begin
                if (status.div_done) begin
                    cmd.v_take = 1'b1;
                    state_next = is_acc ? S_ASTART : S_VPUSH;
                end
            end
            S_ASTART: begin
                if (status.elap_zero) begin
                    cmd.a_zero = 1'b1;
                    state_next = S_APUSH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = erest_pkg::SRC_ACC;
                    state_next    = S_ADIV;
                end
            end
            S_ADIV: begin
                if (status.div_done) begin
                    cmd.a_take = 1'b1;
                    state_next = S_APUSH;
                end
            end
            S_APUSH: begin
                cmd.a_push = 1'b1;
                state_next = S_VPUSH;
            end
            S_VPUSH: begin
                cmd.v_push = 1'b1;
                state_next = S_SUMCLR;
            end
            S_SUMCLR: begin
                cmd.sum_clear = 1'b1;
                state_next    = S_SUMRD;
            end
            S_SUMRD: begin
                cmd.sum_rd = 1'b1;
                if (status.sum_last) begin
                    state_next = S_SUMTAIL;
                end
            end
            S_SUMTAIL: begin
                state_next = S_MSTART;
            end
            S_MSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = erest_pkg::SRC_MEAN;
                state_next    = S_MDIV;
            end
            S_MDIV: begin
                cmd.div_src = erest_pkg::SRC_MEAN;
                if (status.div_done) begin
                    cmd.mean_take = 1'b1;
                    cmd.clear_acc = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            mode_reg    <= erest_pkg::MODE_RST;
            count_reg   <= erest_pkg::SCNT_RST;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    erest_pkg::REG_MODE:  mode_reg  <= cfg_data[erest_pkg::MODE_W-1:0];
                    erest_pkg::REG_COUNT: count_reg <= cfg_data[erest_pkg::SCNT_W-1:0];
                    default: begin
                        mode_reg <= mode_reg;
                    end
                endcase
            end
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

### src/encoder_rate_estimator_core.sv
// Encoder rate estimator.
// Input channel (s_valid/s_ready) carries one query: the encoder counts and
// timer ticks since the previous query. Each request yields exactly one result
// on the output channel (m_valid/m_ready): distance, averaged velocity or
// averaged acceleration in signed fixed point with FRAC_BITS fraction bits,
// plus a clipped flag. Configuration writes (cfg_valid/cfg_ready) set the
// report mode (index 0) and the averaging depth (index 1); write only idle.
// Distance mode and the unused mode go straight on to the output register.
// Velocity mode runs two passes of the shared radix-2 divider (numerator
// width NUM_W = max(48 + FRAC_BITS, 48 + clog2(MAX_SAMPLES + 1)), 64 by
// default): one for the velocity and one for the mean of the averaged
// samples, which are summed in between. Acceleration mode adds a third
// divider pass and its push. One request is in work at a time; the next
// request is taken in the cycle after the result is loaded.
// The result sits in an output register, so a new request is taken while the
// previous result waits; a stalled receiver holds the block only once the
// next result is ready. Reset clears the accumulators and sample counts and
// restores mode 1 with depth 2; history memories need no clearing.
`default_nettype none
module encoder_rate_estimator_core #(
    parameter int MAX_SAMPLES = erest_pkg::MAX_SAMPLES_DEF,
    parameter int FRAC_BITS   = erest_pkg::FRAC_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  signed [erest_pkg::CNT_W-1:0]   s_delta_counts,
    input  wire  [erest_pkg::CNT_W-1:0]          s_delta_ticks,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [erest_pkg::VAL_W-1:0]   m_reported_value,
    output logic                                 m_clipped,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [erest_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [erest_pkg::CFG_DATA_W-1:0]     cfg_data
);

    erest_pkg::cmd_t                  cmd;
    erest_pkg::status_t               status;
    logic [$clog2(MAX_SAMPLES+1)-1:0] n_eff;

    erest_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .n_eff     (n_eff)
    );

    erest_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .n_eff        (n_eff),
        .delta_counts (s_delta_counts),
        .delta_ticks  (s_delta_ticks),
        .status       (status),
        .out_value    (m_reported_value),
        .out_clip     (m_clipped)
    );

endmodule
`default_nettype wire
